### src/bcsm_pkg.sv
// Package for the six-step commutation and stall monitor: codes and constants.
package bcsm_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_START    = 2'd0,
    FUNC_CROSSING = 2'd1,
    FUNC_TIMEOUT  = 2'd2,
    FUNC_BLANK_END = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FAIL_LIMIT = 2'd0,
    CFG_MAX_DUTY   = 2'd1,
    CFG_HIGH_LIMIT = 2'd2,
    CFG_LOW_LIMIT  = 2'd3
  } cfg_reg_t;

  localparam int DUTY_BITS_DEFAULT = 12;
  localparam int STEPS             = 6;
  localparam int IVAL_W            = 16;
  localparam int SUM_W             = 19;
  localparam int CFG_W             = 16;

  localparam logic [IVAL_W-1:0] TIMEOUT_INTERVAL   = 16'hFFFF;
  localparam logic [7:0]        FAIL_LIMIT_RESET   = 8'd20;
  localparam logic [15:0]       HIGH_LIMIT_RESET   = 16'd15000;
  localparam logic [15:0]       LOW_LIMIT_RESET    = 16'd100;
  localparam logic [7:0]        SCORE_MAX          = 8'hFF;

  // ceil(2^22 / 3): x/3 == (x * DIV3_RECIP) >> 22 for x < 2^21
  localparam int                DIV3_SHIFT = 22;
  localparam logic [20:0]       DIV3_RECIP = 21'd1398102;

endpackage

### src/bldc_commutation_stall_monitor_top.sv
// Six-step sensorless commutation engine with stall scoring and duty slew.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    func, interval, duty_command
//  out       source     out_valid / out_ready  phase_step .. average_interval
//  cfg       sink       cfg_en                 cfg_index, cfg_data
//
// One request per cycle sustained while out_ready holds; each request passes
// through the input register, then through the update logic into the result register.
// The update of history, sum, average (constant reciprocal multiply) and score
// is combinational between the registers, so the next request sees the new state at once.
// Reset (synchronous, rst high) clears engine state and valid flags, loads register defaults.
// A stalled output holds the result register and the input register in place.
module bldc_commutation_stall_monitor_top #(
  parameter int DUTY_BITS = bcsm_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_en,
  input  logic [1:0]            cfg_index,
  input  logic [bcsm_pkg::CFG_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [15:0]           interval,
  input  logic [DUTY_BITS-1:0]  duty_command,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            phase_step,
  output logic                  edge_rising,
  output logic [13:0]           blanking_ticks,
  output logic [DUTY_BITS-1:0]  duty_level,
  output logic                  duty_changed,
  output logic                  commutated,
  output logic                  running,
  output logic                  stall_stop,
  output logic [7:0]            fail_score,
  output logic [15:0]           average_interval
);

  localparam int STEPS  = bcsm_pkg::STEPS;
  localparam int IVAL_W = bcsm_pkg::IVAL_W;
  localparam int SUM_W  = bcsm_pkg::SUM_W;
  localparam int PROD_W = SUM_W - 1 + 21;

  // configuration registers
  logic [7:0]           fail_limit;
  logic [DUTY_BITS-1:0] max_duty;
  logic [IVAL_W-1:0]    interval_high_limit;
  logic [IVAL_W-1:0]    interval_low_limit;

  // engine state
  logic [IVAL_W-1:0]    hist [STEPS];
  logic [SUM_W-1:0]     interval_sum;
  logic [2:0]           step_index;
  logic [7:0]           stall_score;
  logic [2:0]           phase_count;
  logic [DUTY_BITS-1:0] duty_now;
  logic                 run_active;
  logic                 blanking_active;
  logic                 timeout_pending;

  // input register
  logic                 req_valid;
  bcsm_pkg::func_t      req_func;
  logic [IVAL_W-1:0]    req_interval;
  logic [DUTY_BITS-1:0] req_cmd;

  logic advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // next-state logic
  logic [IVAL_W-1:0]    hist_next [STEPS];
  logic [SUM_W-1:0]     sum_next;
  logic [2:0]           step_next;
  logic [7:0]           score_next;
  logic [2:0]           phase_next;
  logic [DUTY_BITS-1:0] duty_next;
  logic                 run_next;
  logic                 blank_next;
  logic                 pending_next;
  logic                 changed_next;
  logic                 commut_next;
  logic                 stop_next;

  logic [IVAL_W-1:0]    ival;
  logic [IVAL_W-1:0]    mx;
  logic [IVAL_W-1:0]    mn;
  logic [PROD_W-1:0]    prod;
  logic [IVAL_W-1:0]    avg_next;
  logic                 suspect;
  logic [7:0]           score_upd;
  logic [DUTY_BITS-1:0] duty_inc;

  // average of the sum that this request leaves behind
  assign prod     = PROD_W'(sum_next[SUM_W-1:1]) * PROD_W'(bcsm_pkg::DIV3_RECIP);
  assign avg_next = prod[bcsm_pkg::DIV3_SHIFT +: IVAL_W];

  always_comb begin
    hist_next    = hist;
    sum_next     = interval_sum;
    step_next    = step_index;
    score_next   = stall_score;
    phase_next   = phase_count;
    duty_next    = duty_now;
    run_next     = run_active;
    blank_next   = blanking_active;
    pending_next = timeout_pending;
    changed_next = 1'b0;
    commut_next  = 1'b0;
    stop_next    = 1'b0;
    ival         = timeout_pending ? bcsm_pkg::TIMEOUT_INTERVAL : req_interval;
    mx           = '0;
    mn           = '1;
    suspect      = 1'b0;
    score_upd    = stall_score;
    duty_inc     = duty_now + DUTY_BITS'(1);

    unique case (req_func)
      bcsm_pkg::FUNC_START: begin
        for (int i = 0; i < STEPS; i++) begin
          hist_next[i] = '0;
        end
        sum_next     = '0;
        step_next    = '0;
        score_next   = '0;
        phase_next   = '0;
        blank_next   = 1'b0;
        run_next     = 1'b1;
        duty_next    = req_cmd;
        changed_next = 1'b1;
      end
      bcsm_pkg::FUNC_CROSSING: begin
        if (run_active && !blanking_active) begin
          pending_next          = 1'b0;
          hist_next[step_index] = ival;
          sum_next = interval_sum - SUM_W'(hist[step_index]) + SUM_W'(ival);
          for (int i = 0; i < STEPS; i++) begin
            if (hist_next[i] > mx) mx = hist_next[i];
            if (hist_next[i] < mn) mn = hist_next[i];
          end
          phase_next = (phase_count == 3'(STEPS - 1)) ? 3'd0 : phase_count + 3'd1;
          suspect = ((mx >> 1) > avg_next) || ({1'b0, mn, 1'b0} < {1'b0, avg_next}) ||
                    (mx > interval_high_limit) || (mn < interval_low_limit);
          if (suspect) begin
            if (stall_score != bcsm_pkg::SCORE_MAX) score_upd = stall_score + 8'd1;
          end else if (stall_score != 8'd0) begin
            score_upd = stall_score - 8'd1;
          end
          score_next = score_upd;
          if (score_upd > fail_limit) begin
            run_next     = 1'b0;
            blank_next   = 1'b0;
            duty_next    = '0;
            changed_next = 1'b1;
            stop_next    = 1'b1;
          end else begin
            // every sixth commutation, slew duty up one count (capped at max_duty) or set it to the command
            if (phase_next == 3'd0) begin
              if (req_cmd > duty_now) begin
                duty_next = (duty_inc > max_duty) ? max_duty : duty_inc;
              end else begin
                duty_next = req_cmd;
              end
              changed_next = 1'b1;
            end
            blank_next  = 1'b1;
            step_next   = (step_index == 3'(STEPS - 1)) ? 3'd0 : step_index + 3'd1;
            commut_next = 1'b1;
          end
        end
      end
      bcsm_pkg::FUNC_TIMEOUT: begin
        pending_next = 1'b1;
        if (run_active) begin
          run_next     = 1'b0;
          blank_next   = 1'b0;
          duty_next    = '0;
          changed_next = 1'b1;
          stop_next    = 1'b1;
        end
      end
      bcsm_pkg::FUNC_BLANK_END: begin
        blank_next = 1'b0;
      end
      default: begin
        blank_next = blanking_active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit          <= bcsm_pkg::FAIL_LIMIT_RESET;
      max_duty            <= '1;
      interval_high_limit <= bcsm_pkg::HIGH_LIMIT_RESET;
      interval_low_limit  <= bcsm_pkg::LOW_LIMIT_RESET;
    end else if (cfg_en) begin
      unique case (bcsm_pkg::cfg_reg_t'(cfg_index))
        bcsm_pkg::CFG_FAIL_LIMIT: fail_limit          <= cfg_data[7:0];
        bcsm_pkg::CFG_MAX_DUTY:   max_duty            <= cfg_data[DUTY_BITS-1:0];
        bcsm_pkg::CFG_HIGH_LIMIT: interval_high_limit <= cfg_data[IVAL_W-1:0];
        bcsm_pkg::CFG_LOW_LIMIT:  interval_low_limit  <= cfg_data[IVAL_W-1:0];
        default:                  fail_limit          <= fail_limit;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_func     <= bcsm_pkg::func_t'(func);
      req_interval <= interval;
      req_cmd      <= duty_command;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STEPS; i++) begin
        hist[i] <= '0;
      end
      interval_sum    <= '0;
      step_index      <= '0;
      stall_score     <= '0;
      phase_count     <= '0;
      duty_now        <= '0;
      run_active      <= 1'b0;
      blanking_active <= 1'b0;
      timeout_pending <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        hist            <= hist_next;
        interval_sum    <= sum_next;
        step_index      <= step_next;
        stall_score     <= score_next;
        phase_count     <= phase_next;
        duty_now        <= duty_next;
        run_active      <= run_next;
        blanking_active <= blank_next;
        timeout_pending <= pending_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      phase_step       <= step_next;
      edge_rising      <= step_next[0];
      blanking_ticks   <= avg_next[IVAL_W-1:2];
      duty_level       <= duty_next;
      duty_changed     <= changed_next;
      commutated       <= commut_next;
      running          <= run_next;
      stall_stop       <= stop_next;
      fail_score       <= score_next;
      average_interval <= avg_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= 3'(STEPS - 1) && phase_count <= 3'(STEPS - 1))
    else $error("step or phase count out of range");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && stall_stop |-> !running && duty_level == '0)
    else $error("stop result still running or driving duty");

  a_commut_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && commutated |-> running && !stall_stop && blanking_active)
    else $error("commutation reported while stopped");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && running == run_active && fail_score == stall_score)
    else $error("result register does not match engine state");

endmodule

### bench/bldc_commutation_stall_monitor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the commutation and stall monitor: directed table, random runs.
module bldc_commutation_stall_monitor_top_tb;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int QUIET_LIMIT = 400;
  localparam int MAX_PRINTS  = 40;
  localparam int N_DIR       = 24;

  typedef struct packed {
    bcsm_pkg::func_t func;
    logic [15:0]     ival;
    logic [11:0]     cmd;
  } engine_req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        rising;
    logic [13:0] blank_ticks;
    logic [11:0] duty;
    logic        duty_chg;
    logic        comm;
    logic        run;
    logic        stop;
    logic [7:0]  score;
    logic [15:0] avg;
  } motor_status_t;

  typedef struct packed {
    bcsm_pkg::func_t func;
    logic [15:0]     ival;
    logic [11:0]     cmd;
    logic            typed;
    logic [11:0]     t_duty;
    logic            t_chg;
    logic            t_run;
  } dir_row_t;

  // typed rows: everything but duty, duty_changed and running reads zero
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // stopped after reset: crossing, blank end and timeout show nothing
    '{bcsm_pkg::FUNC_CROSSING,  16'hFFFF, 12'hFFF, 1'b1, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'h0000, 12'h000, 1'b1, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_TIMEOUT,   16'hFFFF, 12'hFFF, 1'b1, 12'h000, 1'b0, 1'b0},
    // start takes full command unclamped
    '{bcsm_pkg::FUNC_START,     16'h0000, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 1'b1},
    // first crossing takes the timeout interval, the second is blanked
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'hFFFF, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'h0000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'h0000, 12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_START,     16'hFFFF, 12'h000, 1'b1, 12'h000, 1'b1, 1'b1},
    // six commutations, duty slews up one on the sixth
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_BLANK_END, 16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    // timeout while running, then a crossing while stopped
    '{bcsm_pkg::FUNC_TIMEOUT,   16'd0,    12'h000, 1'b0, 12'h000, 1'b0, 1'b0},
    '{bcsm_pkg::FUNC_CROSSING,  16'd1000, 12'hFFF, 1'b0, 12'h000, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [15:0] interval = '0;
  logic [11:0] duty_command = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  phase_step;
  logic        edge_rising;
  logic [13:0] blanking_ticks;
  logic [11:0] duty_level;
  logic        duty_changed;
  logic        commutated;
  logic        running;
  logic        stall_stop;
  logic [7:0]  fail_score;
  logic [15:0] average_interval;

  bldc_commutation_stall_monitor_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_en           (cfg_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .interval         (interval),
    .duty_command     (duty_command),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .phase_step       (phase_step),
    .edge_rising      (edge_rising),
    .blanking_ticks   (blanking_ticks),
    .duty_level       (duty_level),
    .duty_changed     (duty_changed),
    .commutated       (commutated),
    .running          (running),
    .stall_stop       (stall_stop),
    .fail_score       (fail_score),
    .average_interval (average_interval)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine copy: limits, interval history and run state
  logic [7:0]  lim_fail = bcsm_pkg::FAIL_LIMIT_RESET;
  logic [11:0] lim_duty = 12'hFFF;
  logic [15:0] lim_high = bcsm_pkg::HIGH_LIMIT_RESET;
  logic [15:0] lim_low  = bcsm_pkg::LOW_LIMIT_RESET;
  logic [15:0] ival_hist [bcsm_pkg::STEPS] = '{default: '0};
  logic [18:0] ival_sum = '0;
  logic [2:0]  step_q = '0;
  logic [7:0]  score_q = '0;
  logic [2:0]  comm_cnt = '0;
  logic [11:0] duty_q = '0;
  logic        run_q = 1'b0;
  logic        blank_q = 1'b0;
  logic        timeout_flag = 1'b0;
  logic        last_ignored = 1'b0;

  motor_status_t status_due [$];
  motor_status_t want;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          quiet = 0;
  int          n_errors = 0;
  int          n_req = 0;
  int          n_live = 0;
  int          n_status = 0;
  int          n_comms = 0;
  int          n_slews = 0;
  int          n_stops = 0;
  int          peak_score = 0;

  function automatic void drop_drive();
    run_q   = 1'b0;
    blank_q = 1'b0;
    duty_q  = '0;
  endfunction

  function automatic motor_status_t step_engine(engine_req_t rq);
    motor_status_t st;
    logic [15:0] iv, mx, mn;
    int unsigned avg;
    bit suspect;
    int k;
    st = '0;
    last_ignored = 1'b0;
    case (rq.func)
      bcsm_pkg::FUNC_START: begin
        for (k = 0; k < bcsm_pkg::STEPS; k++) ival_hist[k] = '0;
        ival_sum = '0;
        step_q   = '0;
        score_q  = '0;
        comm_cnt = '0;
        blank_q  = 1'b0;
        run_q    = 1'b1;
        duty_q   = rq.cmd;
        st.duty_chg = 1'b1;
      end
      bcsm_pkg::FUNC_CROSSING: begin
        if (run_q && !blank_q) begin
          iv = timeout_flag ? bcsm_pkg::TIMEOUT_INTERVAL : rq.ival;
          timeout_flag = 1'b0;
          ival_sum = ival_sum - 19'(ival_hist[step_q]);
          ival_hist[step_q] = iv;
          ival_sum = ival_sum + 19'(iv);
          mx = '0;
          mn = '1;
          for (k = 0; k < bcsm_pkg::STEPS; k++) begin
            if (ival_hist[k] > mx) mx = ival_hist[k];
            if (ival_hist[k] < mn) mn = ival_hist[k];
          end
          avg = 32'(ival_sum) / bcsm_pkg::STEPS;
          comm_cnt = (comm_cnt == 3'(bcsm_pkg::STEPS - 1)) ? 3'd0 : comm_cnt + 3'd1;
          suspect = (32'(mx >> 1) > avg) || ((32'(mn) << 1) < avg) ||
                    (mx > lim_high) || (mn < lim_low);
          if (suspect) begin
            if (score_q != bcsm_pkg::SCORE_MAX) score_q = score_q + 8'd1;
          end else if (score_q != 8'd0) begin
            score_q = score_q - 8'd1;
          end
          if (score_q > lim_fail) begin
            drop_drive();
            st.duty_chg = 1'b1;
            st.stop     = 1'b1;
          end else begin
            // slew once per electrical turn
            if (comm_cnt == 3'd0) begin
              if (rq.cmd > duty_q) begin
                duty_q = duty_q + 12'd1;
                if (duty_q > lim_duty) duty_q = lim_duty;
              end else begin
                duty_q = rq.cmd;
              end
              st.duty_chg = 1'b1;
            end
            blank_q = 1'b1;
            step_q  = (step_q == 3'(bcsm_pkg::STEPS - 1)) ? 3'd0 : step_q + 3'd1;
            st.comm = 1'b1;
          end
        end else begin
          last_ignored = 1'b1;
        end
      end
      bcsm_pkg::FUNC_TIMEOUT: begin
        timeout_flag = 1'b1;
        if (run_q) begin
          drop_drive();
          st.duty_chg = 1'b1;
          st.stop     = 1'b1;
        end
      end
      default: begin
        last_ignored = !blank_q;
        blank_q = 1'b0;
      end
    endcase
    avg = 32'(ival_sum) / bcsm_pkg::STEPS;
    if (avg > 32'hFFFF) avg = 32'hFFFF;
    st.phase       = step_q;
    st.rising      = step_q[0];
    st.blank_ticks = 14'(avg >> 2);
    st.duty        = duty_q;
    st.run         = run_q;
    st.score       = score_q;
    st.avg         = 16'(avg);
    return st;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                n_status, name, got, exp));
  endtask

  // hold valid and payload until taken, then predict
  task automatic send(bcsm_pkg::func_t f, logic [15:0] iv, logic [11:0] cmd);
    engine_req_t rq;
    rq = '{f, iv, cmd};
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    interval     <= iv;
    duty_command <= cmd;
    do @(posedge clk); while (!in_ready);
    status_due.push_back(step_engine(rq));
    n_req++;
    if (!last_ignored) n_live++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bcsm_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bcsm_pkg::CFG_FAIL_LIMIT: lim_fail = val[7:0];
      bcsm_pkg::CFG_MAX_DUTY:   lim_duty = val[11:0];
      bcsm_pkg::CFG_HIGH_LIMIT: lim_high = val;
      default:                  lim_low  = val;
    endcase
  endtask

  task automatic load_limits(int ph);
    logic [15:0] v [4];
    int k;
    case (ph)
      1:       v = '{16'd0, 16'd4095, 16'hFFFF, 16'd0};
      2:       v = '{16'd200, 16'd0, 16'd15000, 16'd100};
      3:       v = '{16'd255, 16'd4095, 16'd0, 16'hFFFF};
      4:       v = '{16'($urandom_range(1, 40)), 16'($urandom_range(0, 4095)),
                     16'($urandom_range(2000, 20000)), 16'($urandom_range(0, 500))};
      5:       v = '{16'd20, 16'd2048, 16'd15000, 16'd100};
      6:       v = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      default: v = '{16'd20, 16'd4095, 16'd15000, 16'd100};
    endcase
    for (k = 0; k < 4; k++) write_reg(bcsm_pkg::cfg_reg_t'(k), v[k]);
    cfg_en <= 1'b0;
  endtask

  task automatic noise_req();
    case ($urandom_range(0, 3))
      0:       send(bcsm_pkg::FUNC_TIMEOUT, 16'($urandom), 12'($urandom));
      1:       send(bcsm_pkg::FUNC_CROSSING, 16'($urandom), 12'($urandom));
      default: send(bcsm_pkg::func_t'($urandom_range(0, 3)), 16'($urandom), 12'($urandom));
    endcase
  endtask

  // start, then crossing / blank-end pairs around a drifting target interval
  task automatic run_burst();
    int unsigned base, jit, n;
    logic [11:0] cmd;
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 600)
                                       : $urandom_range(150, 14000);
    n    = (lim_fail == 8'hFF) ? $urandom_range(260, 300) : $urandom_range(6, 40);
    cmd  = 12'($urandom);
    send(bcsm_pkg::FUNC_START, 16'($urandom),
         ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 16)));
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) cmd = 12'($urandom);
      if ($urandom_range(0, 7) == 0) base = $urandom_range(20, 14000);
      jit = base / 16 + 1;
      send(bcsm_pkg::FUNC_CROSSING, 16'(base - jit + $urandom_range(0, 2 * jit)), cmd);
      if (!run_q) break;
      // a crossing inside blanking must be dropped
      if ($urandom_range(0, 9) == 0) send(bcsm_pkg::FUNC_CROSSING, 16'($urandom), cmd);
      send(bcsm_pkg::FUNC_BLANK_END, 16'($urandom), 12'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = status_due.pop_front();
        check_field("phase_step", 32'(phase_step), 32'(want.phase));
        check_field("edge_rising", 32'(edge_rising), 32'(want.rising));
        check_field("blanking_ticks", 32'(blanking_ticks), 32'(want.blank_ticks));
        check_field("duty_level", 32'(duty_level), 32'(want.duty));
        check_field("duty_changed", 32'(duty_changed), 32'(want.duty_chg));
        check_field("commutated", 32'(commutated), 32'(want.comm));
        check_field("running", 32'(running), 32'(want.run));
        check_field("stall_stop", 32'(stall_stop), 32'(want.stop));
        check_field("fail_score", 32'(fail_score), 32'(want.score));
        check_field("average_interval", 32'(average_interval), 32'(want.avg));
        n_status++;
        if (want.comm) n_comms++;
        if (want.comm && want.duty_chg) n_slews++;
        if (want.stop) n_stops++;
        if (int'(want.score) > peak_score) peak_score = int'(want.score);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet);
      $display("bldc_commutation_stall_monitor_top verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    int ph;
    int goal;
    motor_status_t known;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < N_DIR; k++) begin
      send(DIR_TAB[k].func, DIR_TAB[k].ival, DIR_TAB[k].cmd);
      if (DIR_TAB[k].typed) begin
        known          = '0;
        known.duty     = DIR_TAB[k].t_duty;
        known.duty_chg = DIR_TAB[k].t_chg;
        known.run      = DIR_TAB[k].t_run;
        status_due[status_due.size() - 1] = known;
      end
    end
    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      load_limits(ph);
      goal = n_live + PHASE_ITEMS;
      while (n_live < goal) begin
        idle_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) noise_req();
        else run_burst();
      end
    end
    quiesce();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests (%0d directed) under %0d limit settings,",
             n_req, N_DIR, PHASES);
    $display("%0d results checked: %0d commutations, %0d duty slews, %0d stops, peak score %0d.",
             n_status, n_comms, n_slews, n_stops, peak_score);
    if (n_errors == 0) begin
      $display("bldc_commutation_stall_monitor_top verification clean");
    end else begin
      $display("bldc_commutation_stall_monitor_top verification failed");
    end
    $finish;
  end

endmodule

### bldc_commutation_stall_monitor_top.f
src/bcsm_pkg.sv
src/bldc_commutation_stall_monitor_top.sv
bench/bldc_commutation_stall_monitor_top_tb.sv
